// File: rtl/rcam_pkg.sv
package rcam_pkg;

    // Store geometry
    localparam int MAX_POSITIONS = 1024;
    localparam int VALUE_BITS    = 31;
    localparam int ADDR_BITS     = $clog2(MAX_POSITIONS);

    // Field widths of the channels
    localparam int POS_BITS   = 11;
    localparam int COUNT_BITS = 11;

    // Configuration port
    localparam int APB_ADDR_BITS = 2;
    localparam int APB_DATA_BITS = 32;
    localparam logic [APB_ADDR_BITS-1:0] ADDR_LENGTH = APB_ADDR_BITS'(0);
    localparam logic [POS_BITS-1:0] LENGTH_RESET = POS_BITS'(1024);

    // Largest count the result field can carry
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Input item kinds
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic write_en;
        logic load_query;
        logic scan_step;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_query;
        logic range_empty;
        logic scan_last;
    } status_t;

endpackage

// File: rtl/rcam_if.sv
// Input channel: one write or one query per transaction.
interface rcam_in_if;
    logic                                valid;
    logic                                ready;
    logic                                action;
    logic [rcam_pkg::POS_BITS-1:0]       position;
    logic [rcam_pkg::VALUE_BITS-1:0]     new_value;
    logic [rcam_pkg::POS_BITS-1:0]       range_low;
    logic [rcam_pkg::POS_BITS-1:0]       range_high;
    logic [rcam_pkg::VALUE_BITS-1:0]     bound;

    modport source (
        output valid, action, position, new_value, range_low, range_high, bound,
        input  ready
    );

    modport sink (
        input  valid, action, position, new_value, range_low, range_high, bound,
        output ready
    );
endinterface

// Output channel: one count per query transaction.
interface rcam_out_if;
    logic                                valid;
    logic                                ready;
    logic [rcam_pkg::COUNT_BITS-1:0]     count;

    modport source (
        output valid, count,
        input  ready
    );

    modport sink (
        input  valid, count,
        output ready
    );
endinterface

// File: rtl/rcam_ctrl.sv
module rcam_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  rcam_pkg::status_t status,
    output rcam_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   in_accept;

    // Items are taken only between queries; the output register stands apart.
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // Next state and datapath commands
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (status.is_query)
                    begin
                        cmd.load_query = 1'b1;
                        state_next     = status.range_empty ? ST_FINISH : ST_SCAN;
                    end
                    else
                    begin
                        cmd.write_en = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The result stays valid until the receiver takes it.
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A new result never overwrites one that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten while a transaction was pending");

    // The last scanned position is always followed by the drain cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && status.scan_last) |=> (state_reg == ST_DRAIN))
        else $error("scan did not end in the drain cycle");

    // An empty query range skips the scan entirely.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_query && status.range_empty) |=> (state_reg == ST_FINISH))
        else $error("empty range query entered the scan");

endmodule

// File: rtl/rcam_datapath.sv
module rcam_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rcam_pkg::cmd_t                      cmd,
    output rcam_pkg::status_t                   status,
    input  logic [rcam_pkg::POS_BITS-1:0]       length_q,
    input  logic                                action,
    input  logic [rcam_pkg::POS_BITS-1:0]       position,
    input  logic [rcam_pkg::VALUE_BITS-1:0]     new_value,
    input  logic [rcam_pkg::POS_BITS-1:0]       range_low,
    input  logic [rcam_pkg::POS_BITS-1:0]       range_high,
    input  logic [rcam_pkg::VALUE_BITS-1:0]     bound,
    output logic [rcam_pkg::COUNT_BITS-1:0]     count
);

    logic [rcam_pkg::VALUE_BITS-1:0] mem [rcam_pkg::MAX_POSITIONS];

    logic [rcam_pkg::POS_BITS-1:0]   n_active;
    logic [rcam_pkg::POS_BITS-1:0]   lo_clip;
    logic [rcam_pkg::POS_BITS-1:0]   hi_clip;
    logic                            pos_ok;
    logic [rcam_pkg::ADDR_BITS-1:0]  wr_addr;
    logic [rcam_pkg::ADDR_BITS-1:0]  rd_addr;

    logic [rcam_pkg::POS_BITS-1:0]   ptr_reg;
    logic [rcam_pkg::POS_BITS-1:0]   ptr_next;
    logic [rcam_pkg::POS_BITS-1:0]   hi_reg;
    logic [rcam_pkg::VALUE_BITS-1:0] bound_reg;
    logic [rcam_pkg::VALUE_BITS-1:0] rd_data_reg;
    logic                            cmp_valid_reg;
    logic [rcam_pkg::COUNT_BITS-1:0] cnt_reg;
    logic [rcam_pkg::COUNT_BITS-1:0] cnt_next;
    logic [rcam_pkg::COUNT_BITS-1:0] count_reg;

    // A length above the store size acts as the store size.
    assign n_active = (length_q > rcam_pkg::POS_BITS'(rcam_pkg::MAX_POSITIONS))
                    ? rcam_pkg::POS_BITS'(rcam_pkg::MAX_POSITIONS) : length_q;

    // Clip the query range to the positions in use.
    assign lo_clip = (range_low == '0) ? rcam_pkg::POS_BITS'(1) : range_low;
    assign hi_clip = (range_high > n_active) ? n_active : range_high;

    // Writes outside the positions in use are dropped.
    assign pos_ok  = (position != '0) && (position <= n_active);
    assign wr_addr = rcam_pkg::ADDR_BITS'(position - rcam_pkg::POS_BITS'(1));
    assign rd_addr = rcam_pkg::ADDR_BITS'(ptr_reg - rcam_pkg::POS_BITS'(1));

    assign status.is_query    = (action == rcam_pkg::ACT_QUERY);
    assign status.range_empty = (lo_clip > hi_clip);
    assign status.scan_last   = (ptr_reg == hi_reg);

    assign count = count_reg;

    // Value store: one write port, one registered read port for the scan.
    always_ff @(posedge clk)
    begin
        if (cmd.write_en && pos_ok)
        begin
            mem[wr_addr] <= new_value;
        end
        if (cmd.scan_step)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Scan pointer walks one position per cycle.
    always_comb
    begin
        if (cmd.load_query)
        begin
            ptr_next = lo_clip;
        end
        else if (cmd.scan_step)
        begin
            ptr_next = ptr_reg + rcam_pkg::POS_BITS'(1);
        end
        else
        begin
            ptr_next = ptr_reg;
        end
    end

    // Count the values read back that do not exceed the bound.
    always_comb
    begin
        if (cmd.load_query)
        begin
            cnt_next = '0;
        end
        else if (cmp_valid_reg && (rd_data_reg <= bound_reg)
                 && (cnt_reg != rcam_pkg::COUNT_MAX))
        begin
            cnt_next = cnt_reg + rcam_pkg::COUNT_BITS'(1);
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    // Query operands and the result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_query)
        begin
            hi_reg    <= hi_clip;
            bound_reg <= bound;
        end
        if (cmd.out_load)
        begin
            count_reg <= cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg       <= '0;
            cnt_reg       <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            ptr_reg       <= ptr_next;
            cnt_reg       <= cnt_next;
            cmp_valid_reg <= cmd.scan_step;
        end
    end

    // The scan never reads outside the clipped range.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> (ptr_reg != '0 && ptr_reg <= hi_reg
                           && ptr_reg <= rcam_pkg::POS_BITS'(rcam_pkg::MAX_POSITIONS)))
        else $error("scan pointer left the queried range");

endmodule

// File: rtl/range_count_at_most_with_updates.sv
// Range count "at most" with updates.
// The block keeps a store of up to 1024 values at positions 1..length_in_use.
// Input channel (in_ch): a write transaction stores new_value at position; a
// query transaction asks how many values in range_low..range_high are not
// above bound. Output channel (out_ch): one count per query, none per write.
// Configuration: length_in_use sits at APB address 0; the user writes it only
// while the block is idle, which the block itself does not enforce. pready is
// always high. A write is taken and the next item may follow at once. A query
// scans the clipped range one position per cycle through the single read port
// of the value store, then passes a drain state and a finish state, where the
// count is loaded into the output register and the input is freed again; an
// empty range goes straight to the finish state.
// The count waits in an output register; the next item is accepted while it
// waits, and only a later query result is held back until it is taken.
// Reset clears the control state and sets length_in_use to 1024. The value
// store is not cleared; positions must be written before a query covers them.
module range_count_at_most_with_updates (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [rcam_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  logic [rcam_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic [rcam_pkg::APB_DATA_BITS-1:0]    prdata,
    output logic                                  pready,
    rcam_in_if.sink                               in_ch,
    rcam_out_if.source                            out_ch
);

    logic [rcam_pkg::POS_BITS-1:0] length_reg;
    logic                          cfg_write;
    rcam_pkg::cmd_t                cmd;
    rcam_pkg::status_t             status;

    // Configuration port: one register, written at any address, read at 0.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        prdata = '0;
        if (paddr == rcam_pkg::ADDR_LENGTH)
        begin
            prdata = rcam_pkg::APB_DATA_BITS'(length_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= rcam_pkg::LENGTH_RESET;
        end
        else if (cfg_write)
        begin
            length_reg <= pwdata[rcam_pkg::POS_BITS-1:0];
        end
    end

    // Sequencing of writes, scans and results
    rcam_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Value store, scan pointer and counter
    rcam_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .length_q   (length_reg),
        .action     (in_ch.action),
        .position   (in_ch.position),
        .new_value  (in_ch.new_value),
        .range_low  (in_ch.range_low),
        .range_high (in_ch.range_high),
        .bound      (in_ch.bound),
        .count      (out_ch.count)
    );

endmodule
